// ===== src/jan_pkg.sv =====
// shared constants and control structs for the joystick axis normalizer
// no dependencies
package jan_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 3'd5;

    // width of the offset register
    localparam int OFFSET_W = 16;

    // control bits carried alongside the normalizing divider
    typedef struct packed {
        logic neg;
        logic full;
    } norm_ctl_t;

    // control bits carried alongside the dead zone divider
    typedef struct packed {
        logic neg;
        logic full;
        logic zero;
        logic bypass;
    } dz_ctl_t;

endpackage

// ===== src/jan_frac_div.sv =====
// pipelined fractional divider, one quotient bit per stage: quo = num * 2^QW / den
// requires num < den; depends on nothing but its parameters
module jan_frac_div #(
    parameter int DW = 12,
    parameter int QW = 14,
    parameter int SW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    // per stage registers
    logic          v_reg [QW];
    logic [DW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [SW-1:0] s_reg [QW];

    // stage inputs, index 0 from the ports
    logic          p_v [QW+1];
    logic [DW-1:0] p_r [QW+1];
    logic [DW-1:0] p_d [QW+1];
    logic [QW-1:0] p_q [QW+1];
    logic [SW-1:0] p_s [QW+1];
    logic          adv [QW+1];

    assign p_v[0] = in_valid;
    assign p_r[0] = num;
    assign p_d[0] = den;
    assign p_q[0] = '0;
    assign p_s[0] = side_in;
    assign adv[QW] = out_ready;
    assign in_ready = adv[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   t;
        logic          bit_q;
        logic [DW-1:0] r_next;

        // one restoring step
        assign t      = {p_r[k], 1'b0};
        assign bit_q  = (t >= {1'b0, p_d[k]});
        assign r_next = bit_q ? DW'(t - {1'b0, p_d[k]}) : t[DW-1:0];

        // a stage takes new data when empty or when its successor moves
        assign adv[k] = !v_reg[k] || adv[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv[k])
            begin
                v_reg[k] <= p_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                r_reg[k] <= r_next;
                d_reg[k] <= p_d[k];
                q_reg[k] <= {p_q[k][QW-2:0], bit_q};
                s_reg[k] <= p_s[k];
            end
        end

        assign p_v[k+1] = v_reg[k];
        assign p_r[k+1] = r_reg[k];
        assign p_d[k+1] = d_reg[k];
        assign p_q[k+1] = q_reg[k];
        assign p_s[k+1] = s_reg[k];
    end

    assign out_valid = p_v[QW];
    assign quo       = p_q[QW];
    assign side_out  = p_s[QW];

endmodule

// ===== src/joystick_axis_normalizer_unit.sv =====
// Joystick axis normalizer: maps a raw ADC code to a signed fixed-point position where
// 2^FRAC_BITS is full deflection, using end stop and center calibration, an offset, an
// optional sign flip and a rescaled dead zone. One sample is taken every cycle unless
// back-pressure from position_ready stalls the pipeline, which is built around two
// one-bit-per-stage divider pipelines (calibration scaling, then dead zone rescaling).
// Configuration registers may be written only while no transaction is in flight.
// depends on jan_pkg and jan_frac_div
module joystick_axis_normalizer_unit #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 14,
    localparam int CFG_W = (jan_pkg::OFFSET_W > FRAC_BITS + 1)
                           ? ((jan_pkg::OFFSET_W > ADC_BITS) ? jan_pkg::OFFSET_W : ADC_BITS)
                           : ((FRAC_BITS + 1 > ADC_BITS) ? FRAC_BITS + 1 : ADC_BITS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [jan_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic [ADC_BITS-1:0]            sample,
    output logic                           position_valid,
    input  logic                           position_ready,
    output logic signed [FRAC_BITS+2:0]    position
);
    import jan_pkg::*;

    localparam int A  = ADC_BITS;
    localparam int F  = FRAC_BITS;
    localparam int WW = ((F + 2 > OFFSET_W) ? F + 2 : OFFSET_W) + 2;
    localparam int S2W = $bits(dz_ctl_t) + F + 3;
    localparam logic [A-1:0] FULL_CODE = {A{1'b1}};
    localparam logic [A-1:0] HALF_CODE = A'(1) << (A - 1);
    localparam logic [F:0]   ONE_MAG   = (F+1)'(1) << F;
    localparam logic signed [WW-1:0]  LIM_W   = WW'(2) << F;
    localparam logic signed [F+2:0]   LIM_POS = (F+3)'(2) << F;
    localparam logic signed [F+2:0]   ONE_POS = (F+3)'(1) << F;

    // configuration registers
    logic [A-1:0]        min_reg, max_reg, center_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                reverse_reg;
    logic [F:0]          dead_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            max_reg       <= FULL_CODE;
            center_reg    <= HALF_CODE;
            offset_reg    <= '0;
            reverse_reg   <= 1'b0;
            dead_band_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN:       min_reg       <= cfg_data[A-1:0];
                REG_MAX:       max_reg       <= cfg_data[A-1:0];
                REG_CENTER:    center_reg    <= cfg_data[A-1:0];
                REG_OFFSET:    offset_reg    <= cfg_data[OFFSET_W-1:0];
                REG_REVERSE:   reverse_reg   <= cfg_data[0];
                REG_DEAD_BAND: dead_band_reg <= cfg_data[F:0];
                default:       ;
            endcase
        end
    end

    // calibration select: magnitude and divisor of the normalizing division
    logic          cal_ok, above;
    logic [A:0]    code2;
    logic [A-1:0]  n_mag, n_den, n_num;
    norm_ctl_t     n_ctl;

    always_comb
    begin
        cal_ok = (min_reg < center_reg) && (center_reg < max_reg);
        above  = (sample >= center_reg);
        code2  = {sample, 1'b0};
        if (cal_ok)
        begin
            n_mag     = above ? A'(sample - center_reg) : A'(center_reg - sample);
            n_den     = above ? A'(max_reg - center_reg) : A'(center_reg - min_reg);
            n_ctl.neg = !above;
        end
        else
        begin
            n_mag     = (sample >= HALF_CODE) ? A'(code2 - {1'b0, FULL_CODE})
                                              : A'({1'b0, FULL_CODE} - code2);
            n_den     = FULL_CODE;
            n_ctl.neg = (sample < HALF_CODE);
        end
        n_ctl.full = (n_mag >= n_den);
        n_num      = n_ctl.full ? '0 : n_mag;
    end

    logic          d1_valid, d1_ready;
    logic [F-1:0]  d1_quo;
    logic [1:0]    d1_side;
    norm_ctl_t     d1_ctl;

    jan_frac_div #(.DW(A), .QW(F), .SW($bits(norm_ctl_t))) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .num       (n_num),
        .den       (n_den),
        .side_in   (n_ctl),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    assign d1_ctl = norm_ctl_t'(d1_side);

    // stage 2: signed normalized value in [-1, 1]
    logic                    s2_v_reg;
    logic signed [F+1:0]     s2_val_reg;
    logic [F:0]              v1_mag;
    logic                    adv2, adv3, adv4;

    assign v1_mag = d1_ctl.full ? ONE_MAG : {1'b0, d1_quo};
    assign adv2     = !s2_v_reg || adv3;
    assign d1_ready = adv2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_v_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_val_reg <= d1_ctl.neg ? -$signed({1'b0, v1_mag}) : $signed({1'b0, v1_mag});
        end
    end

    // stage 3: offset, reverse and saturation to [-2, 2]
    logic                    s3_v_reg;
    logic signed [F+2:0]     s3_val_reg;
    logic signed [F+2:0]     s3_val_next;
    logic signed [WW-1:0]    w_sub, w_rev;

    always_comb
    begin
        w_sub = WW'(s2_val_reg) - WW'($signed(offset_reg));
        w_rev = reverse_reg ? -w_sub : w_sub;
        if (w_rev > LIM_W)
        begin
            s3_val_next = LIM_POS;
        end
        else if (w_rev < -LIM_W)
        begin
            s3_val_next = -LIM_POS;
        end
        else
        begin
            s3_val_next = w_rev[F+2:0];
        end
    end

    logic d2_in_ready;
    assign adv3 = !s3_v_reg || d2_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv3)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_val_reg <= s3_val_next;
        end
    end

    // dead zone setup for the rescaling division
    logic [F+1:0]  z_mag, z_a;
    logic [F:0]    z_d;
    logic [F-1:0]  z_num;
    dz_ctl_t       z_ctl;

    always_comb
    begin
        z_mag        = s3_val_reg[F+2] ? (F+2)'(-s3_val_reg) : s3_val_reg[F+1:0];
        z_ctl.neg    = s3_val_reg[F+2];
        z_ctl.bypass = (dead_band_reg == '0);
        z_ctl.zero   = (dead_band_reg >= ONE_MAG) || (z_mag <= (F+2)'(dead_band_reg));
        z_a          = z_mag - (F+2)'(dead_band_reg);
        z_d          = ONE_MAG - dead_band_reg;
        z_ctl.full   = (z_a >= (F+2)'(z_d));
        z_num        = (z_ctl.full || z_ctl.zero) ? '0 : z_a[F-1:0];
    end

    logic            d2_valid;
    logic [F-1:0]    d2_quo;
    logic [S2W-1:0]  d2_side;
    dz_ctl_t         d2_ctl;
    logic signed [F+2:0] d2_val;

    jan_frac_div #(.DW(F), .QW(F), .SW(S2W)) u_dz_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .in_ready  (d2_in_ready),
        .num       (z_num),
        .den       (z_d[F-1:0]),
        .side_in   ({z_ctl, s3_val_reg}),
        .out_valid (d2_valid),
        .out_ready (adv4),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    assign d2_ctl = dz_ctl_t'(d2_side[S2W-1:F+3]);
    assign d2_val = $signed(d2_side[F+2:0]);

    // output register
    logic                  out_v_reg;
    logic signed [F+2:0]   out_reg;
    logic signed [F+2:0]   out_next;
    logic signed [F+2:0]   s_mag;

    always_comb
    begin
        s_mag = d2_ctl.full ? ONE_POS : $signed((F+3)'(d2_quo));
        if (d2_ctl.bypass)
        begin
            out_next = d2_val;
        end
        else if (d2_ctl.zero)
        begin
            out_next = '0;
        end
        else
        begin
            out_next = d2_ctl.neg ? -s_mag : s_mag;
        end
    end

    assign adv4 = !out_v_reg || position_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv4)
        begin
            out_v_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            out_reg <= out_next;
        end
    end

    assign position_valid = out_v_reg;
    assign position       = out_reg;

    // range checks on delivered transactions
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_valid |-> (position <= LIM_POS) && (position >= -LIM_POS))
        else $error("position outside saturation range");

    a_full_dead_zone: assert property (@(posedge clk) disable iff (!rst_n)
        position_valid && (dead_band_reg >= ONE_MAG) |-> (position == '0))
        else $error("full dead zone gave a nonzero position");

    a_dead_zone_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        position_valid && (dead_band_reg != '0)
            |-> (position <= ONE_POS) && (position >= -ONE_POS))
        else $error("dead zone output beyond full deflection");

endmodule
